// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/rbsa_pkg.sv
// ----------------------------------------------------------------------------
// rbsa_pkg
// Types, codes and helpers shared by the bump and frame-stack allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsa_pkg;

	localparam int unsigned ALIGN_BYTES     = 16;
	localparam int unsigned FRAME_TAG_BYTES = 8;
	localparam int unsigned FRAME_DEPTH_DEF = 64;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned TOP_W  = 33;
	localparam int unsigned LEN_W  = 34;
	localparam int unsigned ADDR_W = 4;

	localparam logic [DATA_W-1:0] RST_BUFFER_LENGTH = 32'd65536;
	localparam logic [DATA_W-1:0] RST_DATA_LENGTH   = 32'd16384;
	localparam logic [DATA_W-1:0] RST_DATA_MAX      = 32'd4096;
	localparam logic [DATA_W-1:0] RST_STACK_MAX     = 32'd4096;

	typedef enum logic [1:0] {
		REG_BUFFER_LENGTH = 2'd0,
		REG_DATA_LENGTH   = 2'd1,
		REG_DATA_MAX      = 2'd2,
		REG_STACK_MAX     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_PUSH    = 2'd1,
		KIND_POP     = 2'd2,
		KIND_POP_ALT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STATUS_OK         = 3'd0,
		STATUS_TOO_LARGE  = 3'd1,
		STATUS_NO_SPACE   = 3'd2,
		STATUS_NO_FRAME   = 3'd3,
		STATUS_STORE_FULL = 3'd4
	} status_t;

	// Configuration as seen by the request engine.
	typedef struct packed {
		logic [DATA_W-1:0] data_max_request;
		logic [DATA_W-1:0] stack_max_request;
		logic [DATA_W-1:0] boundary;
		logic              restart;
		logic [TOP_W-1:0]  restart_top;
	} cfg_t;

	function automatic logic [LEN_W-1:0] round_up(input logic [LEN_W-1:0] x);
		logic [LEN_W-1:0] s;
		s = x + LEN_W'(ALIGN_BYTES - 1);
		return LEN_W'((s / ALIGN_BYTES) * ALIGN_BYTES);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rbsa_req_if.sv
// ----------------------------------------------------------------------------
// rbsa_req_if
// Request channel: kind and requested length with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbsa_req_if import rbsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [DATA_W-1:0] request_length;

	modport source (output valid, kind, request_length, input ready);
	modport sink (input valid, kind, request_length, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rbsa_rsp_if.sv
// ----------------------------------------------------------------------------
// rbsa_rsp_if
// Result channel: granted offset and status with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbsa_rsp_if import rbsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] granted_offset;
	logic [2:0]        status;

	modport source (output valid, granted_offset, status, input ready);
	modport sink (input valid, granted_offset, status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rbsa_cfg.sv
// ----------------------------------------------------------------------------
// rbsa_cfg
// APB register file holding the buffer geometry and request limits.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsa_cfg import rbsa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [DATA_W-1:0] buffer_length_q, data_length_q, data_max_q, stack_max_q, boundary_q;
	logic [DATA_W-1:0] buffer_length_nxt, data_length_nxt;
	logic              wr;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	assign buffer_length_nxt = (wr && idx == REG_BUFFER_LENGTH) ? pwdata : buffer_length_q;
	assign data_length_nxt   = (wr && idx == REG_DATA_LENGTH) ? pwdata : data_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= RST_BUFFER_LENGTH;
			data_length_q   <= RST_DATA_LENGTH;
			data_max_q      <= RST_DATA_MAX;
			stack_max_q     <= RST_STACK_MAX;
			boundary_q      <= RST_DATA_LENGTH;
		end else if (wr) begin
			buffer_length_q <= buffer_length_nxt;
			data_length_q   <= data_length_nxt;
			// The data segment never reaches past the buffer end.
			boundary_q      <= (data_length_nxt < buffer_length_nxt) ? data_length_nxt
			                                                          : buffer_length_nxt;
			if (idx == REG_DATA_MAX) begin
				data_max_q <= pwdata;
			end
			if (idx == REG_STACK_MAX) begin
				stack_max_q <= pwdata;
			end
		end
	end

	always_comb begin
		unique case (idx)
			REG_BUFFER_LENGTH: prdata = buffer_length_q;
			REG_DATA_LENGTH:   prdata = data_length_q;
			REG_DATA_MAX:      prdata = data_max_q;
			REG_STACK_MAX:     prdata = stack_max_q;
			default:           prdata = '0;
		endcase
	end

	assign cfg.data_max_request  = data_max_q;
	assign cfg.stack_max_request = stack_max_q;
	assign cfg.boundary          = boundary_q;
	assign cfg.restart           = wr && (idx == REG_BUFFER_LENGTH || idx == REG_DATA_LENGTH);
	assign cfg.restart_top       = {1'b0, buffer_length_nxt};

endmodule

`default_nettype wire

// File: hw/rtl/rbsa_frame_mem.sv
// ----------------------------------------------------------------------------
// rbsa_frame_mem
// Frame length store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsa_frame_mem import rbsa_pkg::*; #(
	parameter int unsigned DEPTH = FRAME_DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [TOP_W-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [TOP_W-1:0] rd_data
);

	logic [TOP_W-1:0] mem_q [DEPTH];
	logic [TOP_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/rbsa_ctrl.sv
// ----------------------------------------------------------------------------
// rbsa_ctrl
// Request engine: pointer checks and updates, frame store access, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsa_ctrl import rbsa_pkg::*; #(
	parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF,
	parameter int unsigned AW          = $clog2(FRAME_DEPTH),
	parameter int unsigned CW          = $clog2(FRAME_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	rbsa_req_if.sink              req,
	rbsa_rsp_if.source            rsp,
	output logic                  mem_wr_en,
	output logic      [AW-1:0]    mem_wr_addr,
	output logic      [TOP_W-1:0] mem_wr_data,
	output logic                  mem_rd_en,
	output logic      [AW-1:0]    mem_rd_addr,
	input  wire logic [TOP_W-1:0] mem_rd_data
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t            state_q;
	logic              accept, done;

	kind_t             kind_s1;
	logic [DATA_W-1:0] req_s1;
	logic [LEN_W-1:0]  len_s1;

	logic [DATA_W-1:0] data_top_q, data_top_d;
	logic [TOP_W-1:0]  stack_top_q, stack_top_d;
	logic [CW-1:0]     count_q, count_d;

	logic              out_valid_q;
	logic [DATA_W-1:0] offset_q, res_offset;
	status_t           status_q, res_status;

	logic [LEN_W-1:0]  sum_data, stack_ext, stack_diff, bound_ext;
	logic [TOP_W-1:0]  stack_pop;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid & req.ready;
	// A result leaves the engine once the output register is free or draining.
	assign done      = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);

	// The top frame length is fetched while the request is captured.
	assign mem_rd_en   = accept;
	assign mem_rd_addr = AW'(count_q - 1'b1);
	assign mem_wr_addr = count_q[AW-1:0];
	assign mem_wr_data = len_s1[TOP_W-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_t'(req.kind);
			req_s1  <= req.request_length;
			if (kind_t'(req.kind) == KIND_PUSH) begin
				len_s1 <= round_up({2'b00, req.request_length} + LEN_W'(FRAME_TAG_BYTES));
			end else begin
				len_s1 <= round_up({2'b00, req.request_length});
			end
		end
	end

	assign sum_data   = {2'b00, data_top_q} + len_s1;
	assign stack_ext  = {1'b0, stack_top_q};
	assign stack_diff = stack_ext - len_s1;
	assign bound_ext  = {2'b00, cfg.boundary};
	assign stack_pop  = stack_top_q + mem_rd_data;

	always_comb begin
		res_status  = STATUS_OK;
		res_offset  = '0;
		data_top_d  = data_top_q;
		stack_top_d = stack_top_q;
		count_d     = count_q;
		mem_wr_en   = 1'b0;
		unique case (kind_s1) inside
			KIND_DATA: begin
				if (req_s1 > cfg.data_max_request) begin
					res_status = STATUS_TOO_LARGE;
				end else if (sum_data > bound_ext) begin
					res_status = STATUS_NO_SPACE;
				end else begin
					res_offset = data_top_q;
					data_top_d = sum_data[DATA_W-1:0];
				end
			end
			KIND_PUSH: begin
				if (req_s1 > cfg.stack_max_request) begin
					res_status = STATUS_TOO_LARGE;
				end else if (stack_ext < len_s1 || stack_diff < bound_ext) begin
					res_status = STATUS_NO_SPACE;
				end else if (count_q >= CW'(FRAME_DEPTH)) begin
					res_status = STATUS_STORE_FULL;
				end else begin
					stack_top_d = stack_diff[TOP_W-1:0];
					count_d     = count_q + 1'b1;
					mem_wr_en   = done;
					res_offset  = stack_diff[DATA_W-1:0] + DATA_W'(FRAME_TAG_BYTES);
				end
			end
			KIND_POP, KIND_POP_ALT: begin
				if (count_q == '0) begin
					res_status = STATUS_NO_FRAME;
				end else begin
					count_d     = count_q - 1'b1;
					stack_top_d = stack_pop;
					res_offset  = stack_pop[DATA_W-1:0];
				end
			end
			default: res_status = STATUS_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: if (done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_top_q  <= '0;
			stack_top_q <= {1'b0, RST_BUFFER_LENGTH};
			count_q     <= '0;
		end else if (cfg.restart) begin
			data_top_q  <= '0;
			stack_top_q <= cfg.restart_top;
			count_q     <= '0;
		end else if (done) begin
			data_top_q  <= data_top_d;
			stack_top_q <= stack_top_d;
			count_q     <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			offset_q <= res_offset;
			status_q <= res_status;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.granted_offset = offset_q;
	assign rsp.status         = status_q;

endmodule

`default_nettype wire

// File: hw/rtl/region_bump_and_stack_allocator_core.sv
// ----------------------------------------------------------------------------
// region_bump_and_stack_allocator_core
// A transferred request is held in the request registers and checked in the execute state,
// then its result is registered in the output register; no new request is taken before that.
// A waiting result lets one more request transfer in and holds it until the result leaves.
// Reset: pointers restart (data top at zero, stack top at buffer_length, no frames);
// registers return to defaults. Writing buffer_length or data_length restarts too.
// ----------------------------------------------------------------------------
`default_nettype none

module region_bump_and_stack_allocator_core import rbsa_pkg::*; #(
	parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	rbsa_req_if.sink               req,
	rbsa_rsp_if.source             rsp
);

	localparam int unsigned AW = $clog2(FRAME_DEPTH);
	localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);

	cfg_t             cfg;
	logic             mem_wr_en, mem_rd_en;
	logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
	logic [TOP_W-1:0] mem_wr_data, mem_rd_data;

	rbsa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbsa_frame_mem #(
		.DEPTH (FRAME_DEPTH),
		.AW    (AW)
	) u_frame_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	rbsa_ctrl #(
		.FRAME_DEPTH (FRAME_DEPTH),
		.AW          (AW),
		.CW          (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.req         (req),
		.rsp         (rsp),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

endmodule

`default_nettype wire

// File: hw/rtl/rbsa_checker.sv
// ----------------------------------------------------------------------------
// rbsa_checker
// Port-level checks on the allocator core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rbsa_checker import rbsa_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic [DATA_W-1:0] granted_offset,
	input wire logic [2:0]        status
);

	// A refused request always reports a zero offset.
	`ASSERT_IMPLIES(a_err_zero_offset, clk, arst_n, rsp_valid && status != STATUS_OK, granted_offset == '0, "error result with nonzero offset")

	`ASSERT_IMPLIES(a_status_range, clk, arst_n, rsp_valid, status <= STATUS_STORE_FULL, "status code out of range")

	// One request is in work at a time.
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(granted_offset) && $stable(status), "stalled result changed")

endmodule

bind region_bump_and_stack_allocator_core rbsa_checker u_rbsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.granted_offset (rsp.granted_offset),
	.status         (rsp.status)
);

`default_nettype wire
